// ===== rtl/core/tcp_sack_block_list_defines.svh =====
// Assertion helpers shared by the SACK block list RTL.
`ifndef TCP_SACK_BLOCK_LIST_DEFINES_SVH
`define TCP_SACK_BLOCK_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SACKBL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SACKBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sackbl_pkg.sv =====
`default_nettype none

package sackbl_pkg;

    localparam int MAX_BLOCKS = 4;
    localparam int NUM_SLOTS  = 4;
    localparam int SEQ_W      = 32;
    localparam int CNT_W      = 3;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef logic [SEQ_W-1:0] seq_t;

    typedef struct packed {
        logic op;
        seq_t first_seq;
        seq_t end_seq;
    } sackbl_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] block_count;
        seq_t             blk0_start;
        seq_t             blk0_end;
        seq_t             blk1_start;
        seq_t             blk1_end;
        seq_t             blk2_start;
        seq_t             blk2_end;
        seq_t             blk3_start;
        seq_t             blk3_end;
    } sackbl_rsp_t;

    typedef struct packed {
        seq_t start_seq;
        seq_t end_seq;
    } sackbl_blk_t;

    typedef struct packed {
        logic pop;
        logic push;
        logic ins;
    } sackbl_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_ABSORB,
        ST_CLEAR,
        ST_INSERT,
        ST_REPORT
    } sackbl_state_t;

    function automatic logic ser_le(seq_t a, seq_t b);
        seq_t d;
        d = b - a;
        return !d[SEQ_W-1];
    endfunction

    function automatic logic ser_lt(seq_t a, seq_t b);
        seq_t d;
        d = b - a;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

    function automatic logic blk_overlap(sackbl_blk_t x, sackbl_blk_t y);
        return ser_le(x.start_seq, y.end_seq) && ser_le(y.start_seq, x.end_seq);
    endfunction

    // ties at half range keep the first argument
    function automatic sackbl_blk_t blk_merge(sackbl_blk_t keep, sackbl_blk_t other);
        sackbl_blk_t r;
        r.start_seq = ser_lt(other.start_seq, keep.start_seq) ? other.start_seq
                                                                : keep.start_seq;
        r.end_seq   = ser_lt(keep.end_seq, other.end_seq) ? other.end_seq
                                                            : keep.end_seq;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sackbl_cell.sv =====
`default_nettype none

module sackbl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_cell,
    input  sackbl_pkg::sackbl_cmd_t cmd,
    input  sackbl_pkg::sackbl_blk_t fill,
    input  logic                left_valid,
    input  sackbl_pkg::sackbl_blk_t left_blk,
    input  logic                right_valid,
    input  sackbl_pkg::sackbl_blk_t right_blk,
    output logic                valid,
    output sackbl_pkg::sackbl_blk_t blk
);
    import sackbl_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    sackbl_blk_t blk_reg;
    sackbl_blk_t blk_next;

    always_comb
    begin
        valid_next = valid_reg;
        blk_next   = blk_reg;
        if (cmd.ins)
        begin
            valid_next = left_valid;
            blk_next   = left_blk;
        end
        else if (cmd.pop)
        begin
            // take the pushed block when this becomes the first free slot
            if (cmd.push && !right_valid && (head_cell || valid_reg))
            begin
                valid_next = 1'b1;
                blk_next   = fill;
            end
            else
            begin
                valid_next = right_valid;
                blk_next   = right_blk;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign valid = valid_reg;
    assign blk   = blk_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sackbl_ctrl.sv =====
`default_nettype none

`include "tcp_sack_block_list_defines.svh"

module sackbl_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  sackbl_pkg::sackbl_req_t request,
    input  sackbl_pkg::sackbl_blk_t head_blk,
    output logic                    busy,
    output sackbl_pkg::sackbl_cmd_t cmd,
    output sackbl_pkg::sackbl_blk_t fill,
    output logic [sackbl_pkg::CNT_W-1:0] count,
    output logic                    report
);
    import sackbl_pkg::*;

    sackbl_state_t    state_reg;
    sackbl_state_t    state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;
    logic             found_reg;
    logic             found_next;
    sackbl_blk_t      acc_reg;
    sackbl_blk_t      acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        found_next  = found_reg;
        acc_next    = acc_reg;
        cmd         = '0;
        fill        = head_blk;
        report      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next.start_seq = request.first_seq;
                    acc_next.end_seq   = request.end_seq;
                    found_next         = 1'b0;
                    remain_next        = count_reg;
                    unique case (request.op)
                        OP_RECORD: state_next = (count_reg == '0) ? ST_INSERT : ST_FIND;
                        OP_CLEAR:  state_next = (count_reg == '0) ? ST_REPORT : ST_CLEAR;
                    endcase
                end
            end
            ST_FIND:
            begin
                cmd.pop     = 1'b1;
                remain_next = remain_reg - 1'b1;
                if (!found_reg && blk_overlap(acc_reg, head_blk))
                begin
                    found_next = 1'b1;
                    acc_next   = blk_merge(head_blk, acc_reg);
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
                if (remain_reg == CNT_W'(1))
                begin
                    if (found_next && (count_next != '0))
                    begin
                        state_next  = ST_ABSORB;
                        remain_next = count_next;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_ABSORB:
            begin
                cmd.pop     = 1'b1;
                remain_next = remain_reg - 1'b1;
                if (blk_overlap(acc_reg, head_blk))
                begin
                    acc_next   = blk_merge(acc_reg, head_blk);
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_CLEAR:
            begin
                cmd.pop     = 1'b1;
                remain_next = remain_reg - 1'b1;
                if (ser_le(head_blk.end_seq, acc_reg.start_seq))
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_INSERT:
            begin
                // on a full list the last cell falls off
                cmd.ins = 1'b1;
                fill    = acc_reg;
                if (count_reg != CNT_W'(MAX_BLOCKS))
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                report     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy  = (state_reg != ST_IDLE);
    assign count = count_reg;

    `SACKBL_ASSERT_NEXT(a_accept_starts, start && !busy, state_reg != ST_IDLE, "request lost")
    `SACKBL_ASSERT_IMPL(a_merge_room, (state_reg == ST_INSERT) && found_reg, count_reg < CNT_W'(MAX_BLOCKS), "merged block finds no free cell")
    `SACKBL_ASSERT_IMPL(a_scan_nonempty, (state_reg == ST_FIND) || (state_reg == ST_ABSORB) || (state_reg == ST_CLEAR), remain_reg != '0, "scan runs past the list")

endmodule

`default_nettype wire

// ===== rtl/core/tcp_sack_block_list.sv =====
// Receiver-side SACK block list, most recent block first.
// Request channel: start, request (op, first_seq, end_seq); a request is taken
// at a rising edge with start high and busy low. op record merges or inserts a
// range, op clear drops every block ending at or before first_seq.
// Result channel: done is high for one cycle with result holding block_count and
// the four blocks; slots at or beyond block_count read as zero. The receiver
// cannot stall, so nothing waits on it.
// Blocks sit in a row of cells; a request streams the list through the head
// compare/merge unit one block per cycle, kept blocks wrap to the tail.
// Busy spans the scan states and the report state: record scans the list once,
// again after a merge if blocks remain, then inserts; clear scans once. done
// follows in the next cycle, and a new request may be taken in that same cycle.
// Reset empties the list.

`default_nettype none

`include "tcp_sack_block_list_defines.svh"

module tcp_sack_block_list (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  sackbl_pkg::sackbl_req_t request,
    output logic                    busy,
    output logic                    done,
    output sackbl_pkg::sackbl_rsp_t result
);
    import sackbl_pkg::*;

    sackbl_cmd_t      cmd;
    sackbl_blk_t      fill;
    logic [CNT_W-1:0] count;
    logic             report;
    logic [MAX_BLOCKS-1:0] cell_valid;
    sackbl_blk_t      cell_blk [MAX_BLOCKS];
    sackbl_blk_t      slot_blk [NUM_SLOTS];
    logic [MAX_BLOCKS:0] valid_plus_one;
    logic             done_reg;
    sackbl_rsp_t      result_reg;
    sackbl_rsp_t      result_next;

    sackbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .head_blk (cell_blk[0]),
        .busy     (busy),
        .cmd      (cmd),
        .fill     (fill),
        .count    (count),
        .report   (report)
    );

    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        logic        lv;
        sackbl_blk_t lb;
        logic        rv;
        sackbl_blk_t rb;

        if (k == 0)
        begin : g_first
            assign lv = 1'b1;
            assign lb = fill;
        end
        else
        begin : g_inner
            assign lv = cell_valid[k-1];
            assign lb = cell_blk[k-1];
        end

        if (k == MAX_BLOCKS - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rb = '0;
        end
        else
        begin : g_next
            assign rv = cell_valid[k+1];
            assign rb = cell_blk[k+1];
        end

        sackbl_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .head_cell   (k == 0),
            .cmd         (cmd),
            .fill        (fill),
            .left_valid  (lv),
            .left_blk    (lb),
            .right_valid (rv),
            .right_blk   (rb),
            .valid       (cell_valid[k]),
            .blk         (cell_blk[k])
        );
    end

    for (genvar k = 0; k < NUM_SLOTS; k++)
    begin : g_slot
        if (k < MAX_BLOCKS)
        begin : g_used
            assign slot_blk[k] = cell_valid[k] ? cell_blk[k] : '0;
        end
        else
        begin : g_unused
            assign slot_blk[k] = '0;
        end
    end

    always_comb
    begin
        result_next.block_count = count;
        result_next.blk0_start  = slot_blk[0].start_seq;
        result_next.blk0_end    = slot_blk[0].end_seq;
        result_next.blk1_start  = slot_blk[1].start_seq;
        result_next.blk1_end    = slot_blk[1].end_seq;
        result_next.blk2_start  = slot_blk[2].start_seq;
        result_next.blk2_end    = slot_blk[2].end_seq;
        result_next.blk3_start  = slot_blk[3].start_seq;
        result_next.blk3_end    = slot_blk[3].end_seq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    assign valid_plus_one = {1'b0, cell_valid} + 1'b1;

    `SACKBL_ASSERT_IMPL(a_idle_count, !busy, count == $countones(cell_valid), "count disagrees with cells")
    `SACKBL_ASSERT_IMPL(a_valid_prefix, !busy, $onehot(valid_plus_one), "cells not packed at the head")
    `SACKBL_ASSERT_IMPL(a_done_idle, done, !busy, "result strobed while busy")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

class sack_list_scoreboard;
    sackbl_pkg::seq_t        blk_lo[sackbl_pkg::NUM_SLOTS];
    sackbl_pkg::seq_t        blk_hi[sackbl_pkg::NUM_SLOTS];
    int                      live;
    sackbl_pkg::sackbl_rsp_t expected_lists[$];
    string                   field_name[9];
    int unsigned             mismatches;
    int unsigned             compared;
    int unsigned             records;
    int unsigned             clears;

    function new();
        live = 0;
        mismatches = 0;
        compared = 0;
        records = 0;
        clears = 0;
        field_name = '{"block_count", "blk0_start", "blk0_end", "blk1_start", "blk1_end",
                       "blk2_start", "blk2_end", "blk3_start", "blk3_end"};
        for (int k = 0; k < sackbl_pkg::NUM_SLOTS; k++)
        begin
            blk_lo[k] = '0;
            blk_hi[k] = '0;
        end
    endfunction

    function bit seq_le(sackbl_pkg::seq_t a, sackbl_pkg::seq_t b);
        sackbl_pkg::seq_t d;
        d = b - a;
        return !d[sackbl_pkg::SEQ_W-1];
    endfunction

    function bit seq_lt(sackbl_pkg::seq_t a, sackbl_pkg::seq_t b);
        sackbl_pkg::seq_t d;
        d = b - a;
        return (d != '0) && !d[sackbl_pkg::SEQ_W-1];
    endfunction

    function void drop_at(int k);
        for (int j = k; j + 1 < live; j++)
        begin
            blk_lo[j] = blk_lo[j+1];
            blk_hi[j] = blk_hi[j+1];
        end
        if (live > 0)
        begin
            live--;
            blk_lo[live] = '0;
            blk_hi[live] = '0;
        end
    endfunction

    function void merge_range(sackbl_pkg::seq_t s, sackbl_pkg::seq_t e);
        sackbl_pkg::seq_t lo;
        sackbl_pkg::seq_t hi;
        int               j;
        for (int i = 0; i < live; i++)
        begin
            if (seq_le(s, blk_hi[i]) && seq_le(blk_lo[i], e))
            begin
                lo = seq_lt(s, blk_lo[i]) ? s : blk_lo[i];
                hi = seq_lt(blk_hi[i], e) ? e : blk_hi[i];
                for (j = i; j > 0; j--)
                begin
                    blk_lo[j] = blk_lo[j-1];
                    blk_hi[j] = blk_hi[j-1];
                end
                blk_lo[0] = lo;
                blk_hi[0] = hi;
                j = 1;
                while (j < live)
                begin
                    if (seq_le(blk_lo[j], blk_hi[0]) && seq_le(blk_lo[0], blk_hi[j]))
                    begin
                        blk_lo[0] = seq_lt(blk_lo[j], blk_lo[0]) ? blk_lo[j] : blk_lo[0];
                        blk_hi[0] = seq_lt(blk_hi[0], blk_hi[j]) ? blk_hi[j] : blk_hi[0];
                        drop_at(j);
                    end
                    else
                    begin
                        j++;
                    end
                end
                return;
            end
        end
        if (live >= sackbl_pkg::MAX_BLOCKS)
            drop_at(live - 1);
        for (j = live; j > 0; j--)
        begin
            blk_lo[j] = blk_lo[j-1];
            blk_hi[j] = blk_hi[j-1];
        end
        blk_lo[0] = s;
        blk_hi[0] = e;
        live++;
    endfunction

    function void drop_acked(sackbl_pkg::seq_t ack);
        int i;
        i = 0;
        while (i < live)
        begin
            if (seq_le(blk_hi[i], ack))
                drop_at(i);
            else
                i++;
        end
    endfunction

    function sackbl_pkg::sackbl_rsp_t list_snapshot();
        sackbl_pkg::sackbl_rsp_t r;
        r.block_count = live[sackbl_pkg::CNT_W-1:0];
        r.blk0_start  = (live > 0) ? blk_lo[0] : '0;
        r.blk0_end    = (live > 0) ? blk_hi[0] : '0;
        r.blk1_start  = (live > 1) ? blk_lo[1] : '0;
        r.blk1_end    = (live > 1) ? blk_hi[1] : '0;
        r.blk2_start  = (live > 2) ? blk_lo[2] : '0;
        r.blk2_end    = (live > 2) ? blk_hi[2] : '0;
        r.blk3_start  = (live > 3) ? blk_lo[3] : '0;
        r.blk3_end    = (live > 3) ? blk_hi[3] : '0;
        return r;
    endfunction

    function void note_request(sackbl_pkg::sackbl_req_t req);
        if (req.op == sackbl_pkg::OP_RECORD)
        begin
            merge_range(req.first_seq, req.end_seq);
            records++;
        end
        else
        begin
            drop_acked(req.first_seq);
            clears++;
        end
        expected_lists.push_back(list_snapshot());
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch %0d at %0t: %s", mismatches, $time, what);
    endtask

    function void split(input sackbl_pkg::sackbl_rsp_t r, output sackbl_pkg::seq_t w[9]);
        w[0] = sackbl_pkg::seq_t'(r.block_count);
        w[1] = r.blk0_start;
        w[2] = r.blk0_end;
        w[3] = r.blk1_start;
        w[4] = r.blk1_end;
        w[5] = r.blk2_start;
        w[6] = r.blk2_end;
        w[7] = r.blk3_start;
        w[8] = r.blk3_end;
    endfunction

    task check_result(sackbl_pkg::sackbl_rsp_t got);
        sackbl_pkg::sackbl_rsp_t want;
        sackbl_pkg::seq_t        got_w[9];
        sackbl_pkg::seq_t        want_w[9];
        if (expected_lists.size() == 0)
        begin
            report_mismatch("result with no request pending");
            return;
        end
        want = expected_lists.pop_front();
        split(got, got_w);
        split(want, want_w);
        for (int f = 0; f < 9; f++)
        begin
            if (got_w[f] !== want_w[f])
                report_mismatch($sformatf("%s got %h want %h", field_name[f], got_w[f],
                                          want_w[f]));
        end
        compared++;
    endtask
endclass

module testbench;
    import sackbl_pkg::*;

    localparam int unsigned QUIET_LIMIT = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    sackbl_req_t request = '0;
    logic        busy;
    logic        done;
    sackbl_rsp_t result;

    sack_list_scoreboard sb = new();
    int unsigned         quiet = 0;
    seq_t                win_base = 32'hFFFF_FE00;
    seq_t                last_end = 32'hFFFF_FE00;

    tcp_sack_block_list u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                quiet <= 0;
            end
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    function automatic sackbl_req_t record_req(seq_t s, seq_t e);
        sackbl_req_t r;
        r.op = OP_RECORD;
        r.first_seq = s;
        r.end_seq = e;
        return r;
    endfunction

    function automatic sackbl_req_t clear_req(seq_t ack);
        sackbl_req_t r;
        r.op = OP_CLEAR;
        r.first_seq = ack;
        r.end_seq = $urandom();
        return r;
    endfunction

    // mostly in-window ranges near a moving ack point, some touching, some clears, some noise
    function automatic sackbl_req_t random_segment();
        sackbl_req_t r;
        int unsigned pick;
        seq_t        s;
        pick = $urandom_range(99);
        if ($urandom_range(199) == 0)
            win_base = $urandom();
        if (pick < 60)
        begin
            s = win_base + $urandom_range(0, 600);
            r = record_req(s, s + $urandom_range(1, 150));
        end
        else if (pick < 70)
        begin
            r = record_req(last_end, last_end + $urandom_range(1, 80));
        end
        else if (pick < 90)
        begin
            r = clear_req(win_base + $urandom_range(0, 500));
            if ($urandom_range(1) == 1)
                win_base = r.first_seq;
        end
        else
        begin
            r.op = 1'($urandom_range(1));
            r.first_seq = $urandom();
            r.end_seq = $urandom();
        end
        if (r.op == OP_RECORD)
            last_end = r.end_seq;
        return r;
    endfunction

    task send(sackbl_req_t req);
        start <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(req);
        @(negedge clk);
    endtask

    task idle_gap(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_lists.size() != 0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(clear_req(32'd0));
        send(record_req(32'd100, 32'd200));
        send(record_req(32'd300, 32'd400));
        send(record_req(32'd200, 32'd250));
        send(record_req(32'd500, 32'd600));
        send(record_req(32'd700, 32'd800));
        send(record_req(32'd900, 32'd1000));
        send(record_req(32'd550, 32'd750));
        send(record_req(32'd5000, 32'd4000));
        send(record_req(32'd6000, 32'd6000));
        send(clear_req(32'd1000));
        send(clear_req(32'hFFFF_FFFF));
        send(clear_req(32'd7000));
        send(record_req(32'hFFFF_FFF0, 32'h0000_0010));
        send(record_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(record_req(32'h0000_0000, 32'h0000_0000));
        send(record_req(32'h0000_0000, 32'h8000_0001));
        send(record_req(32'h8000_0000, 32'h0000_0010));
        send(record_req(32'h1000_0000, 32'h9000_0000));
        send(record_req(32'h8FFF_FFF0, 32'h1000_0000));
        send(clear_req(32'h7FFF_FFFF));
        send(clear_req(32'h8000_0000));
        send(record_req(32'hFFFF_FFFF, 32'h0000_0000));
        drain();

        for (int n = 0; n < 700; n++)
        begin
            send(random_segment());
            if (n % 150 == 149)
                drain();
            else if ((n < 250 || n >= 400) && $urandom_range(99) < 8)
                idle_gap($urandom_range(1, 12));
        end
        start <= 1'b0;

        while (sb.expected_lists.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run: %0d requests (%0d record, %0d clear), %0d results compared",
                 sb.records + sb.clears, sb.records, sb.clears, sb.compared);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== tcp_sack_block_list.f =====
+incdir+rtl/core
rtl/core/sackbl_pkg.sv
rtl/core/sackbl_cell.sv
rtl/core/sackbl_ctrl.sv
rtl/core/tcp_sack_block_list.sv
verif/testbench.sv
